@@ sv/json_string_escape_defines.svh @@
// Assertion macros for the JSON string escaper.
`ifndef JSON_STRING_ESCAPE_DEFINES_SVH
`define JSON_STRING_ESCAPE_DEFINES_SVH

`ifndef ASSERT_OFF
`define JSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define JSE_ASSERT_NEVER(lbl, cond, msg) \
  `JSE_ASSERT(lbl, !(cond), msg)
`else
`define JSE_ASSERT(lbl, prop, msg)
`define JSE_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ sv/jse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic RegAsciiOnly = 1'b0;

  localparam logic [1:0] ActStart = 2'd0;
  localparam logic [1:0] ActData  = 2'd1;
  localparam logic [1:0] ActEnd   = 2'd2;

  localparam logic [15:0] ReplacementCp = 16'hfffd;
  localparam logic [15:0] HighSurrBase  = 16'hd800;
  localparam logic [15:0] LowSurrBase   = 16'hdc00;
  localparam logic [20:0] PlaneOne      = 21'h10000;

  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharU      = 8'h75;

  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_CHAR,
    TAIL_ESC,
    TAIL_U16,
    TAIL_PAIR
  } tail_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_TAIL
  } emit_st_e;

  typedef struct packed {
    logic [1:0]  flush;
    tail_e       kind;
    logic [7:0]  ch;
    logic [15:0] v0;
    logic [15:0] v1;
  } job_t;

  typedef struct packed {
    logic [1:0]  held;
    logic [2:0]  seq_len;
    logic [20:0] acc;
  } utf_st_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else begin
      r = 8'h57 + {4'h0, d};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/jse_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

@@ sv/jse_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_end;

  modport source (output valid, output out_char, output run_end, input ready);
  modport sink (input valid, input out_char, input run_end, output ready);
endinterface

`default_nettype wire

@@ sv/jse_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jse_decoder (
  input  wire logic [1:0]       action_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             ascii_only_i,
  input  wire jse_pkg::utf_st_t st_i,
  output jse_pkg::utf_st_t      st_o,
  output jse_pkg::job_t         job_o,
  output logic                  job_valid_o
);
  import jse_pkg::*;

  logic [20:0] acc_n;
  logic [20:0] off;
  logic [15:0] hi;
  logic [15:0] lo;
  logic        cont;
  logic        fresh;
  logic [7:0]  b;

  assign b     = data_byte_i;
  assign acc_n = {st_i.acc[14:0], b[5:0]};
  assign off   = acc_n - PlaneOne;
  assign hi    = HighSurrBase + {5'b0, off[20:10]};
  assign lo    = LowSurrBase + {6'b0, off[9:0]};
  assign cont  = (b[7:6] == 2'b10);

  always_comb begin
    st_o      = st_i;
    job_o     = '0;
    job_o.kind = TAIL_NONE;
    fresh     = 1'b0;

    unique case (action_i)
      ActStart: begin
        st_o       = '0;
        job_o.kind = TAIL_CHAR;
        job_o.ch   = CharQuote;
      end
      ActData: begin
        if (st_i.held != 2'd0 && cont) begin
          if (({1'b0, st_i.held} + 3'd1) >= st_i.seq_len) begin
            st_o = '0;
            if (acc_n[20:16] == 5'd0) begin
              job_o.kind = TAIL_U16;
              job_o.v0   = acc_n[15:0];
            end else begin
              job_o.kind = TAIL_PAIR;
              job_o.v0   = hi;
              job_o.v1   = lo;
            end
          end else begin
            st_o.held = st_i.held + 2'd1;
            st_o.acc  = acc_n;
          end
        end else begin
          job_o.flush = st_i.held;
          st_o        = '0;
          fresh       = 1'b1;
        end
      end
      ActEnd: begin
        job_o.flush = st_i.held;
        st_o        = '0;
        job_o.kind  = TAIL_CHAR;
        job_o.ch    = CharQuote;
      end
      default: begin
      end
    endcase

    if (fresh) begin
      priority if (b == CharQuote) begin
        job_o.kind = TAIL_ESC;
        job_o.ch   = CharQuote;
      end else if (b == CharBslash) begin
        job_o.kind = TAIL_ESC;
        job_o.ch   = CharBslash;
      end else if (b == 8'h08) begin
        job_o.kind = TAIL_ESC;
        job_o.ch   = "b";
      end else if (b == 8'h0c) begin
        job_o.kind = TAIL_ESC;
        job_o.ch   = "f";
      end else if (b == 8'h0a) begin
        job_o.kind = TAIL_ESC;
        job_o.ch   = "n";
      end else if (b == 8'h0d) begin
        job_o.kind = TAIL_ESC;
        job_o.ch   = "r";
      end else if (b == 8'h09) begin
        job_o.kind = TAIL_ESC;
        job_o.ch   = "t";
      end else if (b < 8'h20) begin
        job_o.kind = TAIL_U16;
        job_o.v0   = {8'h00, b};
      end else if (!ascii_only_i || !b[7]) begin
        job_o.kind = TAIL_CHAR;
        job_o.ch   = b;
      end else if (b[7:5] == 3'b110) begin
        st_o.held    = 2'd1;
        st_o.seq_len = 3'd2;
        st_o.acc     = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        st_o.held    = 2'd1;
        st_o.seq_len = 3'd3;
        st_o.acc     = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        st_o.held    = 2'd1;
        st_o.seq_len = 3'd4;
        st_o.acc     = {18'd0, b[2:0]};
      end else begin
        job_o.kind = TAIL_U16;
        job_o.v0   = ReplacementCp;
      end
    end
  end

  assign job_valid_o = (job_o.flush != 2'd0) || (job_o.kind != TAIL_NONE);

endmodule

`default_nettype wire

@@ sv/jse_emitter.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jse_emitter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire jse_pkg::job_t job_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_char_o,
  output logic               out_end_o
);
  import jse_pkg::*;

  emit_st_e    st_q, st_d;
  logic [2:0]  pos_q, pos_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] sh_q, sh_d;
  logic [15:0] v0_q, v0_d;
  logic [15:0] v1_q, v1_d;
  tail_e       kind_q, kind_d;
  logic [7:0]  ch_q, ch_d;
  logic        second_q, second_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_char_q, out_char_d;
  logic        out_end_q, out_end_d;

  logic        step;
  logic        in_u16;
  logic        seg_last;
  logic [7:0]  seg_char;

  assign step   = (st_q != ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_u16 = (st_q == ST_FLUSH) || (kind_q == TAIL_U16) || (kind_q == TAIL_PAIR);

  // shared digit unit: top nibble of the shift register to hex
  always_comb begin
    if (in_u16) begin
      seg_last = (pos_q == 3'd5);
      if (pos_q == 3'd0) begin
        seg_char = CharBslash;
      end else if (pos_q == 3'd1) begin
        seg_char = CharU;
      end else begin
        seg_char = hex_char(sh_q[15:12]);
      end
    end else if (kind_q == TAIL_ESC) begin
      seg_last = (pos_q == 3'd1);
      seg_char = (pos_q == 3'd0) ? CharBslash : ch_q;
    end else begin
      seg_last = 1'b1;
      seg_char = ch_q;
    end
  end

  always_comb begin
    st_d        = st_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    sh_d        = sh_q;
    v0_d        = v0_q;
    v1_d        = v1_q;
    kind_d      = kind_q;
    ch_d        = ch_q;
    second_d    = second_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_end_d   = out_end_q;

    if (load_i) begin
      st_d     = (job_i.flush != 2'd0) ? ST_FLUSH : ST_TAIL;
      cnt_d    = job_i.flush;
      sh_d     = (job_i.flush != 2'd0) ? ReplacementCp : job_i.v0;
      v0_d     = job_i.v0;
      v1_d     = job_i.v1;
      kind_d   = job_i.kind;
      ch_d     = job_i.ch;
      pos_d    = 3'd0;
      second_d = 1'b0;
    end

    if (step) begin
      out_valid_d = 1'b1;
      out_char_d  = seg_char;
      out_end_d   = 1'b0;
      pos_d       = pos_q + 3'd1;
      if (in_u16 && pos_q >= 3'd2) begin
        sh_d = {sh_q[11:0], 4'h0};
      end
      if (seg_last) begin
        pos_d = 3'd0;
        unique case (st_q)
          ST_FLUSH: begin
            if (cnt_q > 2'd1) begin
              cnt_d = cnt_q - 2'd1;
              sh_d  = ReplacementCp;
            end else if (kind_q == TAIL_NONE) begin
              st_d      = ST_IDLE;
              out_end_d = 1'b1;
            end else begin
              st_d = ST_TAIL;
              sh_d = v0_q;
            end
          end
          ST_TAIL: begin
            if (kind_q == TAIL_PAIR && !second_q) begin
              second_d = 1'b1;
              sh_d     = v1_q;
            end else begin
              st_d      = ST_IDLE;
              out_end_d = 1'b1;
            end
          end
          ST_IDLE: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
      pos_q       <= 3'd0;
      second_q    <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q       <= sh_d;
    v0_q       <= v0_d;
    v1_q       <= v1_d;
    kind_q     <= kind_d;
    ch_q       <= ch_d;
    out_char_q <= out_char_d;
    out_end_q  <= out_end_d;
  end

  assign busy_o      = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_end_o   = out_end_q;

endmodule

`default_nettype wire

@@ sv/json_string_escape.sv @@
// JSON string escaper.
// in_i takes framed items: action start, data byte or end. out_o gives the
// quoted, escaped text one character per transfer; run_end marks the last
// character caused by an item. Both use valid/ready; a transfer happens when
// both are high at a rising clock edge.
// Each item is decoded in the cycle it is accepted; its characters are then
// produced by a sequencer around one shared hex digit / shift unit, one
// character per cycle into the output register while out_o is not stalled.
// An item with characters keeps in_i.ready low until its last character
// is in the output register; the job is registered in the sequencer first.
// Items causing no character (a UTF-8 lead or middle byte, unused action)
// leave in_i.ready high. Up to 24 characters per item.
// The next item is accepted while the last character still waits in the
// output register. A stalled receiver holds the output register and stops
// the sequencer.
// APB register 0 (address 0), bit 0: ascii_only, reset 1. Write only while idle.
// Reset clears the UTF-8 gathering state and empties the output.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_escape_defines.svh"

module json_string_escape (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  jse_in_if.sink                              in_i,
  jse_out_if.source                           out_o,
  input  wire logic                           psel_i,
  input  wire logic                           penable_i,
  input  wire logic                           pwrite_i,
  input  wire logic [jse_pkg::ApbAddrW-1:0]   paddr_i,
  input  wire logic [jse_pkg::ApbDataW-1:0]   pwdata_i,
  output logic      [jse_pkg::ApbDataW-1:0]   prdata_o,
  output logic                                pready_o
);
  import jse_pkg::*;

  logic    ascii_q, ascii_d;
  utf_st_t utf_q, utf_d;
  utf_st_t utf_nxt;
  job_t    job;
  logic    job_valid;
  logic    busy;
  logic    in_acc;
  logic    cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == RegAsciiOnly);
  assign ascii_d  = cfg_wr ? pwdata_i[0] : ascii_q;
  assign prdata_o = (paddr_i[2] == RegAsciiOnly) ? {{(ApbDataW-1){1'b0}}, ascii_q} : '0;

  assign in_i.ready = !busy;
  assign in_acc     = in_i.valid && !busy;
  assign utf_d      = in_acc ? utf_nxt : utf_q;

  jse_decoder u_dec (
    .action_i     (in_i.action),
    .data_byte_i  (in_i.data_byte),
    .ascii_only_i (ascii_q),
    .st_i         (utf_q),
    .st_o         (utf_nxt),
    .job_o        (job),
    .job_valid_o  (job_valid)
  );

  jse_emitter u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_acc && job_valid),
    .job_i       (job),
    .busy_o      (busy),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .out_end_o   (out_o.run_end)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ascii_q <= 1'b1;
      utf_q   <= '0;
    end else begin
      ascii_q <= ascii_d;
      utf_q   <= utf_d;
    end
  end

  `JSE_ASSERT(a_job_starts, (in_acc && job_valid) |=> busy, "accepted job did not start")
  `JSE_ASSERT(a_mid_run_busy, (out_o.valid && !out_o.run_end) |-> busy, "run ended early")
  `JSE_ASSERT_NEVER(a_held_bad, (utf_q.held != 2'd0) && (utf_q.held >= utf_q.seq_len), "held count past length")
  `JSE_ASSERT_NEVER(a_idle_len, (utf_q.held == 2'd0) && (utf_q.seq_len != 3'd0), "stale sequence length")

endmodule

`default_nettype wire

@@ test/tb_json_string_escape.sv @@
`timescale 1ns / 1ps

module tb_json_string_escape;
  import jse_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic [ApbAddrW-1:0] AsciiOnlyAddr = ApbAddrW'(4 * int'(RegAsciiOnly));
  localparam int CycleLimit = 600000;
  localparam int NumDirected = 26;
  localparam string HexDigits = "0123456789abcdef";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_xfer_t;

  typedef struct {
    logic [1:0] act;
    logic [7:0] b;
    bit         typed;
    string      text;
  } dir_row_t;

  // Typed rows carry the exact text; the rest go through the escaper model.
  dir_row_t dir_rows [NumDirected] = '{
    '{ActStart,  8'h00, 1'b1, "\""},
    '{ActData,   8'h00, 1'b1, "\\u0000"},
    '{ActData,   8'h1f, 1'b1, "\\u001f"},
    '{ActData,   8'h22, 1'b1, "\\\""},
    '{ActData,   8'h5c, 1'b1, "\\\\"},
    '{ActData,   8'h08, 1'b1, "\\b"},
    '{ActData,   8'h0c, 1'b1, "\\f"},
    '{ActData,   8'h0a, 1'b1, "\\n"},
    '{ActData,   8'h0d, 1'b1, "\\r"},
    '{ActData,   8'h09, 1'b1, "\\t"},
    '{ActData,   8'h7f, 1'b0, ""},
    '{ActData,   8'h80, 1'b1, "\\ufffd"},
    '{ActData,   8'hc3, 1'b1, ""},
    '{ActData,   8'ha9, 1'b0, ""},
    '{ActData,   8'hf0, 1'b1, ""},
    '{ActData,   8'h9f, 1'b0, ""},
    '{ActData,   8'h98, 1'b0, ""},
    '{ActData,   8'hff, 1'b0, ""},
    '{ActData,   8'he2, 1'b0, ""},
    '{ActData,   8'h41, 1'b0, ""},
    '{ActData,   8'hf4, 1'b0, ""},
    '{ActEnd,    8'hff, 1'b0, ""},
    '{ActData,   8'hc3, 1'b0, ""},
    '{ActStart,  8'h5a, 1'b0, ""},
    '{ActUnused, 8'hff, 1'b1, ""},
    '{ActEnd,    8'h00, 1'b1, "\""}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata, prdata;
  logic pready;

  jse_in_if  in_bus ();
  jse_out_if out_bus ();

  json_string_escape u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_bus),
    .out_o     (out_bus),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // escaper model state
  logic        ascii_mode;
  logic [1:0]  utf_held;
  logic [2:0]  utf_len;
  logic [20:0] utf_acc;
  logic [7:0]  item_chars [$];

  char_xfer_t  expected_chars [$];
  int          err_count;
  int          cycle_count;
  int          items_sent;
  int          burst_left;

  function automatic void put_char(input logic [7:0] c);
    item_chars.insert(item_chars.size(), c);
  endfunction

  function automatic void put_u16(input logic [15:0] v);
    put_char(CharBslash);
    put_char(CharU);
    put_char(HexDigits[v[15:12]]);
    put_char(HexDigits[v[11:8]]);
    put_char(HexDigits[v[7:4]]);
    put_char(HexDigits[v[3:0]]);
  endfunction

  function automatic void put_code_point(input logic [20:0] cp);
    logic [20:0] off;
    if (cp <= 21'hffff) begin
      put_u16(cp[15:0]);
    end else begin
      off = cp - PlaneOne;
      put_u16(HighSurrBase + 16'(off >> 10));
      put_u16(LowSurrBase + {6'd0, off[9:0]});
    end
  endfunction

  function automatic void drop_held_as_replacement();
    for (int i = 0; i < int'(utf_held); i++) put_u16(ReplacementCp);
    utf_held = '0;
    utf_len = '0;
    utf_acc = '0;
  endfunction

  function automatic void start_utf(input logic [2:0] len, input logic [20:0] bits);
    utf_held = 2'd1;
    utf_len = len;
    utf_acc = bits;
  endfunction

  function automatic void escape_fresh(input logic [7:0] b);
    case (b)
      CharQuote:  begin put_char(CharBslash); put_char(CharQuote); end
      CharBslash: begin put_char(CharBslash); put_char(CharBslash); end
      8'h08:      begin put_char(CharBslash); put_char("b"); end
      8'h0c:      begin put_char(CharBslash); put_char("f"); end
      8'h0a:      begin put_char(CharBslash); put_char("n"); end
      8'h0d:      begin put_char(CharBslash); put_char("r"); end
      8'h09:      begin put_char(CharBslash); put_char("t"); end
      default: begin
        if (b < 8'h20) begin
          put_u16({8'h00, b});
        end else if (!ascii_mode || b < 8'h80) begin
          put_char(b);
        end else if (b[7:5] == 3'b110) begin
          start_utf(3'd2, {16'd0, b[4:0]});
        end else if (b[7:4] == 4'b1110) begin
          start_utf(3'd3, {17'd0, b[3:0]});
        end else if (b[7:3] == 5'b11110) begin
          start_utf(3'd4, {18'd0, b[2:0]});
        end else begin
          put_u16(ReplacementCp);
        end
      end
    endcase
  endfunction

  function automatic void escape_data(input logic [7:0] b);
    logic [20:0] cp;
    if (utf_held != 0) begin
      if (b[7:6] == 2'b10) begin
        utf_acc = {utf_acc[14:0], b[5:0]};
        if (int'(utf_held) + 1 >= int'(utf_len)) begin
          cp = utf_acc;
          utf_held = '0;
          utf_len = '0;
          utf_acc = '0;
          put_code_point(cp);
        end else begin
          utf_held = utf_held + 2'd1;
        end
        return;
      end
      drop_held_as_replacement();
    end
    escape_fresh(b);
  endfunction

  function automatic void escape_item(input logic [1:0] act, input logic [7:0] b);
    item_chars.delete();
    case (act)
      ActStart: begin
        utf_held = '0;
        utf_len = '0;
        utf_acc = '0;
        put_char(CharQuote);
      end
      ActData: escape_data(b);
      ActEnd: begin
        drop_held_as_replacement();
        put_char(CharQuote);
      end
      default: ;
    endcase
  endfunction

  // Called and returns at a falling edge.
  task automatic send_item(input logic [1:0] act, input logic [7:0] b,
                           input bit typed = 1'b0, input string text = "");
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.data_byte <= b;
    do @(posedge clk_i); while (!in_bus.ready);
    escape_item(act, b);
    if (typed) begin
      item_chars.delete();
      for (int i = 0; i < text.len(); i++) put_char(text[i]);
    end
    foreach (item_chars[i])
      expected_chars.insert(expected_chars.size(),
                            char_xfer_t'{item_chars[i], i == item_chars.size() - 1});
    if (act != ActUnused) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [ApbAddrW-1:0] addr,
                            input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_mode_reg(input logic val);
    logic [ApbDataW-1:0] rd;
    apb_access(1'b0, AsciiOnlyAddr, '0, rd);
    if (rd !== ApbDataW'(val)) begin
      $error("ascii_only expected %0h actual %0h", val, rd);
      err_count++;
    end
  endtask

  task automatic set_mode(input logic val);
    logic [ApbDataW-1:0] rd;
    wait_idle();
    apb_access(1'b1, AsciiOnlyAddr, ApbDataW'(val), rd);
    ascii_mode = val;
    check_mode_reg(val);
  endtask

  task automatic send_utf_lead(input int len);
    case (len)
      2:       send_item(ActData, {3'b110, 5'($urandom)});
      3:       send_item(ActData, {4'b1110, 4'($urandom)});
      default: send_item(ActData, {5'b11110, 3'($urandom)});
    endcase
  endtask

  // One framed string with random content; framing is sometimes left out.
  task automatic rand_string();
    int n_chars, kind, len, k;
    if ($urandom_range(0, 9) != 0) send_item(ActStart, 8'($urandom));
    n_chars = $urandom_range(0, 8);
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: send_item(ActData, 8'($urandom_range(8'h20, 8'h7e)));
        3: begin
          k = $urandom_range(0, 35);
          send_item(ActData, k < 32 ? 8'(k) : k == 32 ? CharQuote :
                             k == 33 ? CharBslash : 8'h7f);
        end
        4, 5, 6: begin
          len = kind - 2;
          send_utf_lead(len);
          for (int j = 0; j < len - 1; j++) send_item(ActData, {2'b10, 6'($urandom)});
        end
        7: begin
          // truncated sequence, broken by whatever follows
          len = $urandom_range(2, 4);
          send_utf_lead(len);
          k = $urandom_range(0, len - 2);
          for (int j = 0; j < k; j++) send_item(ActData, {2'b10, 6'($urandom)});
        end
        8: send_item(ActData, 8'($urandom));
        default: begin
          if ($urandom_range(0, 3) == 0) send_item(ActStart, 8'($urandom));
          else send_item(ActUnused, 8'($urandom));
        end
      endcase
    end
    if ($urandom_range(0, 9) != 0) send_item(ActEnd, 8'($urandom));
  endtask

  always @(posedge clk_i) begin : check_out
    char_xfer_t exp_x;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected transfer out_char=%h run_end=%b", out_bus.out_char, out_bus.run_end);
        err_count++;
      end else begin
        exp_x = expected_chars.pop_front();
        if (out_bus.out_char !== exp_x.ch) begin
          $error("out_char expected %h actual %h", exp_x.ch, out_bus.out_char);
          err_count++;
        end
        if (out_bus.run_end !== exp_x.last) begin
          $error("run_end expected %b actual %b", exp_x.last, out_bus.run_end);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls on a rotating pattern, re-chosen now and then
  initial begin : rx_stall
    logic [15:0] stall_pat;
    int pat_left;
    out_bus.ready = 1'b0;
    pat_left = 0;
    stall_pat = '1;
    forever begin
      @(negedge clk_i);
      if (pat_left == 0) begin
        pat_left = $urandom_range(32, 128);
        case ($urandom_range(0, 2))
          0:       stall_pat = '1;
          1:       stall_pat = 16'($urandom) | 16'h1;
          default: stall_pat = 16'h1 << $urandom_range(0, 15);
        endcase
      end
      out_bus.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      pat_left--;
    end
  end

  initial begin
    int phase_goal;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.action = ActStart;
    in_bus.data_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ascii_mode = 1'b1;
    utf_held = '0;
    utf_len = '0;
    utf_acc = '0;
    err_count = 0;
    cycle_count = 0;
    items_sent = 0;
    burst_left = 0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_mode_reg(1'b1);

    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].text);

    // mode switched while a sequence is half gathered: the sequence still completes
    send_item(ActData, 8'he2);
    send_item(ActData, 8'h82);
    set_mode(1'b0);
    send_item(ActData, 8'hac);

    for (int p = 0; p < 4; p++) begin
      if (p > 0) set_mode(p % 2 == 1);
      phase_goal = items_sent + 46;
      while (items_sent < phase_goal) rand_string();
    end

    wait_idle();
    repeat (30) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
